### rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, opcode encoding and types for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
  localparam int REM_W     = DATA_W + 1;
  localparam int DLY_N     = NUM_W - 2;
  localparam int WIDE_W    = 2 * DATA_W + 1;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             neg;
    logic [DATA_W-1:0] res;
    logic             cmp;
    logic             ovf;
    logic             dz;
  } side_t;

endpackage

### rtl/fpa_div_pipe.sv
// ----------------------------------------------------------------------------
// fpa_div_pipe
// Restoring unsigned divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpa_div_pipe (
  input  logic                      clk,
  input  logic [fpa_pkg::NUM_W-1:0]  dividend,
  input  logic [fpa_pkg::DATA_W-1:0] divisor,
  output logic [fpa_pkg::NUM_W-1:0]  quotient
);
  import fpa_pkg::*;

  logic [REM_W-1:0]  rem_r [NUM_W];
  logic [NUM_W-1:0]  nq_r  [NUM_W];
  logic [DATA_W-1:0] d_r   [NUM_W];

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [NUM_W-1:0]  nq_in;
      logic [DATA_W-1:0] d_in;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign nq_in  = dividend;
        assign d_in   = divisor;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign nq_in  = nq_r[k-1];
        assign d_in   = d_r[k-1];
      end

      assign trial = {rem_in[REM_W-2:0], nq_in[NUM_W-1]};
      assign ge    = trial >= {1'b0, d_in};

      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? (trial - {1'b0, d_in}) : trial;
        nq_r[k]  <= {nq_in[NUM_W-2:0], ge};
        d_r[k]   <= d_in;
      end
    end
  endgenerate

  assign quotient = nq_r[NUM_W-1];

endmodule

### rtl/fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed Q fixed-point ALU: add, sub, mul, div with round half away from
// zero and saturation, comparisons, min/max, inc/dec and conversions.
// Each item travels beside the one-bit-per-stage divider to the output stage.
// Throughput: one item per cycle; busy stays low.
// Reset: rst clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module fixed_point_alu_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [3:0]                 req_type,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
  output logic                       done,
  output logic signed [fpa_pkg::DATA_W-1:0] result_value,
  output logic                       compare_true,
  output logic                       overflow,
  output logic                       divide_by_zero
);
  import fpa_pkg::*;

  localparam logic [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W:0] sat_sum(input logic signed [DATA_W:0] v);
    logic [DATA_W:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = {1'b1, v[DATA_W] ? MIN_V : MAX_V};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DATA_W:0] sat_mag(input logic neg,
                                               input logic [WIDE_W-1:0] mag);
    logic [DATA_W:0] r;
    if (!neg && mag > WIDE_W'(MAX_V)) begin
      r = {1'b1, MAX_V};
    end else if (neg && mag > WIDE_W'(MIN_V)) begin
      r = {1'b1, MIN_V};
    end else begin
      r = {1'b0, neg ? (DATA_W'(0) - mag[DATA_W-1:0]) : mag[DATA_W-1:0]};
    end
    return r;
  endfunction

  // stage 1: input register
  logic                     v1;
  op_t                      op1;
  logic signed [DATA_W-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    op1 <= op_t'(req_type);
    a1  <= operand_a;
    b1  <= operand_b;
  end

  // stage 2: simple ops, magnitudes
  logic              v2;
  side_t             s2, s2_next;
  logic [DATA_W-1:0] ma2, mb2;
  logic [DATA_W:0]   sat_tmp;
  logic [DATA_W+FRAC_BITS-1:0] shl;

  always_comb begin
    s2_next     = '0;
    s2_next.op  = op1;
    s2_next.neg = a1[DATA_W-1] ^ b1[DATA_W-1];
    sat_tmp     = '0;
    shl         = {a1, {FRAC_BITS{1'b0}}};
    case (op1)
      OP_ADD: begin
        sat_tmp = sat_sum({a1[DATA_W-1], a1} + {b1[DATA_W-1], b1});
        {s2_next.ovf, s2_next.res} = sat_tmp;
      end
      OP_SUB: begin
        sat_tmp = sat_sum({a1[DATA_W-1], a1} - {b1[DATA_W-1], b1});
        {s2_next.ovf, s2_next.res} = sat_tmp;
      end
      OP_INC: begin
        sat_tmp = sat_sum({a1[DATA_W-1], a1} + (DATA_W+1)'(1));
        {s2_next.ovf, s2_next.res} = sat_tmp;
      end
      OP_DEC: begin
        sat_tmp = sat_sum({a1[DATA_W-1], a1} - (DATA_W+1)'(1));
        {s2_next.ovf, s2_next.res} = sat_tmp;
      end
      OP_DIV:  s2_next.dz  = (b1 == '0);
      OP_GT:   s2_next.cmp = a1 > b1;
      OP_LT:   s2_next.cmp = a1 < b1;
      OP_GE:   s2_next.cmp = a1 >= b1;
      OP_LE:   s2_next.cmp = a1 <= b1;
      OP_EQ:   s2_next.cmp = a1 == b1;
      OP_NE:   s2_next.cmp = a1 != b1;
      OP_MIN:  s2_next.res = (a1 < b1) ? a1 : b1;
      OP_MAX:  s2_next.res = (a1 > b1) ? a1 : b1;
      OP_FROM_INT: begin
        if (shl[DATA_W+FRAC_BITS-1:DATA_W-1] != {(FRAC_BITS+1){a1[DATA_W-1]}}) begin
          s2_next.ovf = 1'b1;
          s2_next.res = a1[DATA_W-1] ? MIN_V : MAX_V;
        end else begin
          s2_next.res = shl[DATA_W-1:0];
        end
      end
      OP_TO_INT: s2_next.res = a1 >>> FRAC_BITS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2  <= s2_next;
    ma2 <= a1[DATA_W-1] ? (DATA_W'(0) - a1) : a1;
    mb2 <= b1[DATA_W-1] ? (DATA_W'(0) - b1) : b1;
  end

  // divider runs beside stages 3 onward
  logic [NUM_W-1:0] quo;

  fpa_div_pipe u_div (
    .clk      (clk),
    .dividend ({ma2, {FRAC_BITS{1'b0}}, 1'b0}),
    .divisor  (mb2),
    .quotient (quo)
  );

  // stage 3: product
  logic                v3;
  side_t               s3;
  logic [2*DATA_W-1:0] prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3    <= s2;
    prod3 <= ma2 * mb2;
  end

  // stage 4: round and saturate product
  logic            v4;
  side_t           s4, s4_next;
  logic [WIDE_W-1:0] mrnd;
  logic [DATA_W:0] msat;

  always_comb begin
    s4_next = s3;
    mrnd    = (WIDE_W'(prod3) + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    msat    = sat_mag(s3.neg, mrnd);
    if (s3.op == OP_MUL) begin
      {s4_next.ovf, s4_next.res} = msat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4 <= s4_next;
  end

  // align with divider
  logic [DLY_N-1:0] vd;
  side_t            sd [DLY_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[DLY_N-2:0], v4};
    end
    sd[0] <= s4;
    for (int i = 1; i < DLY_N; i++) begin
      sd[i] <= sd[i-1];
    end
  end

  // output stage
  side_t           sl;
  logic [NUM_W:0]  qrnd;
  logic [DATA_W:0] dsat;
  logic [DATA_W-1:0] res_next;
  logic            ovf_next;

  always_comb begin
    sl       = sd[DLY_N-1];
    qrnd     = ({1'b0, quo} + (NUM_W+1)'(1)) >> 1;
    dsat     = sat_mag(sl.neg, WIDE_W'(qrnd));
    res_next = sl.res;
    ovf_next = sl.ovf;
    if (sl.op == OP_DIV && !sl.dz) begin
      {ovf_next, res_next} = dsat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[DLY_N-1];
    end
    result_value   <= res_next;
    compare_true   <= sl.cmp;
    overflow       <= ovf_next;
    divide_by_zero <= sl.dz;
  end

  assign busy = 1'b0;

endmodule

### tb/sv/fixed_point_alu_core_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_core_tb
// Drives random and directed operations into the fixed-point ALU, predicts
// each result with exact wide arithmetic and checks every done strobe in
// order against the oldest prediction.
// ----------------------------------------------------------------------------
module fixed_point_alu_core_tb;
  import fpa_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     cmp;
    logic                     ovf;
    logic                     dz;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int       errors;

    function logic signed [DATA_W-1:0] sat(input logic signed [79:0] v, inout logic ovf);
      if (v > 80'sd2147483647) begin
        ovf = 1'b1;
        return 32'h7fffffff;
      end
      if (v < -80'sd2147483648) begin
        ovf = 1'b1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    function alu_res_t compute(input op_t op, input logic signed [DATA_W-1:0] a,
                               input logic signed [DATA_W-1:0] b);
      alu_res_t r;
      logic signed [79:0] wa, wb, m;
      logic [79:0] ma, mb, p;
      logic neg;
      r = '{value: '0, cmp: 1'b0, ovf: 1'b0, dz: 1'b0};
      wa = a;
      wb = b;
      ma = (wa < 0) ? -wa : wa;
      mb = (wb < 0) ? -wb : wb;
      neg = (a < 0) != (b < 0);
      case (op)
        OP_ADD: r.value = sat(wa + wb, r.ovf);
        OP_SUB: r.value = sat(wa - wb, r.ovf);
        OP_MUL: begin
          p = ((ma * mb) + (80'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          m = neg ? -$signed(p) : $signed(p);
          r.value = sat(m, r.ovf);
        end
        OP_DIV: begin
          if (b == 0) r.dz = 1'b1;
          else begin
            p = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
            m = neg ? -$signed(p) : $signed(p);
            r.value = sat(m, r.ovf);
          end
        end
        OP_GT: r.cmp = a > b;
        OP_LT: r.cmp = a < b;
        OP_GE: r.cmp = a >= b;
        OP_LE: r.cmp = a <= b;
        OP_EQ: r.cmp = a == b;
        OP_NE: r.cmp = a != b;
        OP_MIN: r.value = (a < b) ? a : b;
        OP_MAX: r.value = (a > b) ? a : b;
        OP_INC: r.value = sat(wa + 1, r.ovf);
        OP_DEC: r.value = sat(wa - 1, r.ovf);
        OP_FROM_INT: r.value = sat(wa <<< FRAC_BITS, r.ovf);
        default: r.value = a >>> FRAC_BITS;
      endcase
      return r;
    endfunction

    function void note_item(input op_t op, input logic signed [DATA_W-1:0] a,
                            input logic signed [DATA_W-1:0] b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(input alu_res_t got);
      alu_res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h", $time, got.value);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value || got.cmp !== exp.cmp || got.ovf !== exp.ovf ||
          got.dz !== exp.dz) begin
        $display("%0t: mismatch expected val=%h cmp=%b ovf=%b dz=%b actual val=%h cmp=%b ovf=%b dz=%b",
                 $time, exp.value, exp.cmp, exp.ovf, exp.dz,
                 got.value, got.cmp, got.ovf, got.dz);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  logic [3:0] req_type;
  logic signed [DATA_W-1:0] operand_a, operand_b, result_value;
  logic compare_true, overflow, divide_by_zero;
  alu_scoreboard sb;

  fixed_point_alu_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .result_value(result_value), .compare_true(compare_true),
    .overflow(overflow), .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result('{value: result_value, cmp: compare_true, ovf: overflow,
                        dz: divide_by_zero});
    end
  end

  function logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff - $urandom_range(0, 2);
      1: return 32'h80000000 + $urandom_range(0, 2);
      2: return $signed($urandom_range(0, 4)) - 2;
      3: return $signed($urandom_range(0, 2047)) - 1024;
      4: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
      5: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b);
    start <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    sb.note_item(op, a, b);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= OP_ADD;
    operand_a <= '0;
    operand_b <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int op = 0; op < 16; op++) begin
      send_item(op_t'(op), 32'h7fffffff, 32'h7fffffff);
      send_item(op_t'(op), 32'h80000000, 32'h00000100);
    end
    send_item(OP_DIV, 32'h00000500, 32'h0);
    send_item(OP_DIV, 32'h80000000, 32'hffffffff);
    send_item(OP_MUL, 32'h80000000, 32'h80000000);
    send_item(OP_MUL, 32'h00000001, 32'h00000080);
    send_item(OP_MUL, 32'hffffffff, 32'h00000080);
    send_item(OP_EQ, 32'h12345678, 32'h12345678);
    wait_drained();

    for (int i = 0; i < 1850; i++) begin
      send_item(op_t'($urandom_range(0, 15)), pick_operand(),
                ($urandom_range(0, 15) == 0) ? 32'sd0 : pick_operand());
      if (i == 900) wait_drained();
      else if ($urandom_range(0, 3) != 0) idle_gap();
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### sim.f
rtl/fpa_pkg.sv
rtl/fpa_div_pipe.sv
rtl/fixed_point_alu_core.sv
tb/sv/fixed_point_alu_core_tb.sv
